@@ rtl/skacc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectrum kernel accumulator package
// Shared sizes, request codes and the command/status types that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package skacc_pkg;

    localparam int NUM_STRINGS = 16;
    localparam int MAX_KMER    = 8;
    localparam int SYMBOL_BITS = 8;

    localparam int KEY_W       = 64;
    localparam int FIELD_ID_W  = 4;
    localparam int REQ_W       = 2;
    localparam int KLEN_W      = 4;
    localparam int CNT_W       = 24;
    localparam int KER_W       = 48;

    localparam int ID_W        = $clog2(NUM_STRINGS);
    localparam int STORE_AW    = 2 * ID_W;
    localparam int STORE_DEPTH = 1 << STORE_AW;
    localparam int KBITS_W     = $clog2(MAX_KMER * SYMBOL_BITS + 1);

    localparam logic [CNT_W-1:0]  CNT_MAX    = {CNT_W{1'b1}};
    localparam logic [KER_W-1:0]  KER_MAX    = {KER_W{1'b1}};
    localparam logic [KLEN_W-1:0] KLEN_RESET = KLEN_W'(8);

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_KMER_LENGTH = 1'b0;

    typedef enum logic [REQ_W-1:0] {
        REQ_APPEND = 2'd0,
        REQ_READ   = 2'd1,
        REQ_CLEAR  = 2'd2
    } t_req;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_ROW,
        OP_PICK_A,
        OP_PICK_B,
        OP_MUL,
        OP_WRITE,
        OP_CLOSE_DONE,
        OP_READ_ADDR,
        OP_READ_OUT,
        OP_CLEAR
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic mismatch;
        logic last;
        logic a_any;
        logic b_any;
        logic out_busy;
    } t_dp_sts;

endpackage

@@ rtl/skacc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectrum kernel accumulator controller
// Sequences row counting, group closing, kernel reads and clears.
// ----------------------------------------------------------------------------
module skacc_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic [skacc_pkg::REQ_W-1:0] i_req_type,
    input  skacc_pkg::t_dp_sts       i_sts,
    output skacc_pkg::t_dp_cmd       o_cmd,
    output logic                     o_in_stall
);
    import skacc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ROW,
        ST_PICK_A,
        ST_PICK_B,
        ST_MUL,
        ST_WRITE,
        ST_DONE,
        ST_RADDR,
        ST_ROUT,
        ST_CLEAR
    } t_state;

    t_state r_state, n_state;
    logic   r_pending, n_pending;
    t_req   req;

    assign req        = t_req'(i_req_type);
    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state    = r_state;
        n_pending  = r_pending;
        o_cmd.op   = OP_NONE;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LATCH;
                    case (req)
                        REQ_APPEND: n_state = ST_CHECK;
                        REQ_READ:   n_state = ST_RADDR;
                        REQ_CLEAR:  n_state = ST_CLEAR;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_CHECK: begin
                // A differing key closes the open group before the row counts.
                if (i_sts.mismatch) begin
                    n_pending = 1'b1;
                    n_state   = ST_PICK_A;
                end else begin
                    n_state = ST_ROW;
                end
            end
            ST_ROW: begin
                o_cmd.op  = OP_ROW;
                n_pending = 1'b0;
                n_state   = i_sts.last ? ST_PICK_A : ST_IDLE;
            end
            ST_PICK_A: begin
                if (i_sts.a_any) begin
                    o_cmd.op = OP_PICK_A;
                    n_state  = ST_PICK_B;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_PICK_B: begin
                if (i_sts.b_any) begin
                    o_cmd.op = OP_PICK_B;
                    n_state  = ST_MUL;
                end else begin
                    n_state = ST_PICK_A;
                end
            end
            ST_MUL: begin
                o_cmd.op = OP_MUL;
                n_state  = ST_WRITE;
            end
            ST_WRITE: begin
                o_cmd.op = OP_WRITE;
                n_state  = ST_PICK_B;
            end
            ST_DONE: begin
                o_cmd.op  = OP_CLOSE_DONE;
                n_pending = 1'b0;
                n_state   = r_pending ? ST_ROW : ST_IDLE;
            end
            ST_RADDR: begin
                o_cmd.op = OP_READ_ADDR;
                n_state  = ST_ROUT;
            end
            ST_ROUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.op = OP_READ_OUT;
                    n_state  = ST_IDLE;
                end
            end
            ST_CLEAR: begin
                o_cmd.op = OP_CLEAR;
                n_state  = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pending <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pending <= n_pending;
        end
    end

endmodule

@@ rtl/skacc_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectrum kernel accumulator datapath
// Group key and per-string counts, the pair walk with its multiplier and
// saturating adder, the kernel store and the result register.
// ----------------------------------------------------------------------------
module skacc_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  skacc_pkg::t_dp_cmd                i_cmd,
    output skacc_pkg::t_dp_sts                o_sts,
    input  logic [skacc_pkg::KLEN_W-1:0]      i_kmer_length,
    input  logic [skacc_pkg::KEY_W-1:0]       i_kmer_key,
    input  logic [skacc_pkg::FIELD_ID_W-1:0]  i_string_id,
    input  logic                              i_last_row,
    input  logic [skacc_pkg::FIELD_ID_W-1:0]  i_row_index,
    input  logic [skacc_pkg::FIELD_ID_W-1:0]  i_col_index,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output logic [skacc_pkg::KER_W-1:0]       o_kernel_value,
    output logic                              o_saturated
);
    import skacc_pkg::*;

    function automatic logic [ID_W-1:0] lowest_set(input logic [NUM_STRINGS-1:0] v);
        logic [ID_W-1:0] idx;
        idx = '0;
        for (int i = NUM_STRINGS - 1; i >= 0; i--) begin
            if (v[i]) idx = ID_W'(i);
        end
        return idx;
    endfunction

    // Latched request fields.
    logic [KEY_W-1:0]      r_key;
    logic [FIELD_ID_W-1:0] r_id;
    logic                  r_last;
    logic [FIELD_ID_W-1:0] r_ri;
    logic [FIELD_ID_W-1:0] r_ci;

    // Group state.
    logic [KEY_W-1:0]       r_group_key;
    logic                   r_group_open;
    logic [CNT_W-1:0]       r_cnt [NUM_STRINGS];
    logic [NUM_STRINGS-1:0] r_mask;
    logic                   r_sat_seen;

    // Pair walk.
    logic [NUM_STRINGS-1:0] r_a_used;
    logic [NUM_STRINGS-1:0] r_b_left;
    logic [ID_W-1:0]        r_a;
    logic [ID_W-1:0]        r_b;
    logic [CNT_W-1:0]       r_cnt_a;
    logic [CNT_W-1:0]       r_cnt_b;
    logic [KER_W-1:0]       r_prod;

    // Kernel store; an entry without its valid bit reads as zero.
    logic [KER_W-1:0]       mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] r_vld;
    logic [KER_W-1:0]       r_ram_q;
    logic                   r_ram_vld;
    logic                   r_rd_inrange;

    logic                   r_out_valid;
    logic [KER_W-1:0]       r_out_value;
    logic                   r_out_sat;

    logic [KLEN_W:0]        len_ext;
    logic [KLEN_W:0]        len_c;
    logic [KBITS_W-1:0]     key_bits;
    logic [KEY_W-1:0]       key_mask;
    logic [NUM_STRINGS-1:0] a_left;
    logic [ID_W-1:0]        a_pick;
    logic [ID_W-1:0]        b_pick;
    logic [ID_W-1:0]        id_sel;
    logic                   id_ok;
    logic [ID_W-1:0]        cnt_sel;
    logic [CNT_W-1:0]       cnt_q;
    logic [CNT_W-1:0]       row_cnt;
    logic                   ram_rd;
    logic [STORE_AW-1:0]    ram_raddr;
    logic [KER_W-1:0]       acc_base;
    logic [KER_W:0]         acc_sum;
    logic                   acc_ovf;
    logic [KER_W-1:0]       rd_value;

    always_comb begin
        len_ext = {1'b0, i_kmer_length};
        len_c   = (len_ext > (KLEN_W + 1)'(MAX_KMER)) ? (KLEN_W + 1)'(MAX_KMER) : len_ext;
        key_bits = KBITS_W'(int'(len_c) * SYMBOL_BITS);
        for (int i = 0; i < KEY_W; i++) begin
            key_mask[i] = (i < int'(key_bits));
        end
    end

    assign a_left  = r_mask & ~r_a_used;
    assign a_pick  = lowest_set(a_left);
    assign b_pick  = lowest_set(r_b_left);
    assign id_sel  = ID_W'(r_id);
    assign id_ok   = (int'(r_id) < NUM_STRINGS);

    always_comb begin
        case (i_cmd.op)
            OP_PICK_A: cnt_sel = a_pick;
            OP_PICK_B: cnt_sel = b_pick;
            default:   cnt_sel = id_sel;
        endcase
    end
    assign cnt_q   = r_cnt[cnt_sel];
    assign row_cnt = r_mask[id_sel] ? cnt_q : '0;

    assign ram_rd    = (i_cmd.op == OP_PICK_B) || (i_cmd.op == OP_READ_ADDR);
    assign ram_raddr = (i_cmd.op == OP_PICK_B) ? {r_a, b_pick}
                                               : {ID_W'(r_ri), ID_W'(r_ci)};

    assign acc_base = r_ram_vld ? r_ram_q : '0;
    assign acc_sum  = {1'b0, acc_base} + {1'b0, r_prod};
    assign acc_ovf  = (acc_sum > {1'b0, KER_MAX});
    assign rd_value = (r_rd_inrange && r_ram_vld) ? r_ram_q : '0;

    assign o_sts.mismatch = r_group_open && (((r_group_key ^ r_key) & key_mask) != '0);
    assign o_sts.last     = r_last;
    assign o_sts.a_any    = (a_left != '0);
    assign o_sts.b_any    = (r_b_left != '0);
    assign o_sts.out_busy = r_out_valid && i_out_stall;

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LATCH) begin
            r_key  <= i_kmer_key;
            r_id   <= i_string_id;
            r_last <= i_last_row;
            r_ri   <= i_row_index;
            r_ci   <= i_col_index;
        end
        if (i_cmd.op == OP_ROW) begin
            if (!r_group_open) r_group_key <= r_key;
            if (id_ok && row_cnt != CNT_MAX) r_cnt[id_sel] <= row_cnt + 1'b1;
        end
        if (i_cmd.op == OP_PICK_A) begin
            r_a     <= a_pick;
            r_cnt_a <= cnt_q;
            r_b_left <= r_mask;
        end
        if (i_cmd.op == OP_PICK_B) begin
            r_b     <= b_pick;
            r_cnt_b <= cnt_q;
            r_b_left[b_pick] <= 1'b0;
        end
        if (i_cmd.op == OP_MUL) begin
            r_prod <= r_cnt_a * r_cnt_b;
        end
        if (i_cmd.op == OP_READ_ADDR) begin
            r_rd_inrange <= (int'(r_ri) < NUM_STRINGS) && (int'(r_ci) < NUM_STRINGS);
        end
        if (i_cmd.op == OP_READ_OUT) begin
            r_out_value <= rd_value;
            r_out_sat   <= r_sat_seen || (rd_value == KER_MAX);
        end
    end

    // Kernel store array.
    always_ff @(posedge i_clk) begin
        if (ram_rd) r_ram_q <= mem[ram_raddr];
        if (i_cmd.op == OP_WRITE) mem[{r_a, r_b}] <= acc_ovf ? KER_MAX : acc_sum[KER_W-1:0];
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_open <= 1'b0;
            r_mask       <= '0;
            r_a_used     <= '0;
            r_sat_seen   <= 1'b0;
            r_vld        <= '0;
            r_ram_vld    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (ram_rd) r_ram_vld <= r_vld[ram_raddr];
            // A new result may load in the cycle the previous one is taken.
            if (i_cmd.op == OP_READ_OUT) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                OP_ROW: begin
                    r_group_open <= 1'b1;
                    if (id_ok) begin
                        r_mask[id_sel] <= 1'b1;
                        if (row_cnt == CNT_MAX) r_sat_seen <= 1'b1;
                    end
                end
                OP_PICK_A: begin
                    r_a_used[a_pick] <= 1'b1;
                end
                OP_WRITE: begin
                    r_vld[{r_a, r_b}] <= 1'b1;
                    if (acc_ovf) r_sat_seen <= 1'b1;
                end
                OP_CLOSE_DONE: begin
                    r_group_open <= 1'b0;
                    r_mask       <= '0;
                    r_a_used     <= '0;
                end
                OP_CLEAR: begin
                    r_vld      <= '0;
                    r_sat_seen <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kernel_value = r_out_value;
    assign o_saturated    = r_out_sat;

endmodule

@@ rtl/spectrum_kernel_accumulator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectrum kernel accumulator
// Groups sorted k-mer rows, counts rows per string and accumulates the
// spectrum kernel of every string pair in a 16 by 16 store.
// ----------------------------------------------------------------------------
// The block takes one request per input transfer: append a k-mer row, read
// one kernel entry, or clear the kernel store. Only a read produces an output
// transfer. Requests are handled one at a time; the input stall is low only
// while the controller waits for a new request. A read is held in the
// controller while the previous result still waits on a stalled output.
// Closing a group walks the ordered pairs of strings that have nonzero
// counts, one pair at a time, through a single 24 x 24 multiplier and one
// port of the kernel store; this walk delays the row that closes the group
// (the row flagged last, or the next row with a differing key, which is
// then counted afterwards). The kernel store keeps one valid bit per entry,
// so reset and clear take effect at once with no clearing pass. The
// kmer_length register sits at address 0 of the configuration port and
// must only be written while idle.
module spectrum_kernel_accumulator_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [skacc_pkg::APB_AW-1:0]        paddr,
    input  logic [skacc_pkg::APB_DW-1:0]        pwdata,
    output logic [skacc_pkg::APB_DW-1:0]        prdata,
    output logic                                pready,
    // Request channel.
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [skacc_pkg::REQ_W-1:0]         i_req_type,
    input  logic [skacc_pkg::KEY_W-1:0]         i_kmer_key,
    input  logic [skacc_pkg::FIELD_ID_W-1:0]    i_string_id,
    input  logic                                i_last_row,
    input  logic [skacc_pkg::FIELD_ID_W-1:0]    i_row_index,
    input  logic [skacc_pkg::FIELD_ID_W-1:0]    i_col_index,
    // Result channel.
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [skacc_pkg::KER_W-1:0]         o_kernel_value,
    output logic                                o_saturated
);
    import skacc_pkg::*;

    logic [KLEN_W-1:0] r_kmer_length;
    logic              reg_hit;
    logic              cfg_write;
    t_dp_cmd           cmd;
    t_dp_sts           sts;

    // The word address selects the register; byte offsets are ignored.
    assign reg_hit   = (paddr[APB_AW-1] == REG_KMER_LENGTH);
    assign cfg_write = psel && penable && pwrite && reg_hit;
    assign pready    = 1'b1;
    assign prdata    = reg_hit ? {{(APB_DW - KLEN_W){1'b0}}, r_kmer_length} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_length <= KLEN_RESET;
        end else if (cfg_write) begin
            r_kmer_length <= pwdata[KLEN_W-1:0];
        end
    end

    // The controller owns the request handshake and the sequencing.
    skacc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // The datapath holds all group, kernel and result state.
    skacc_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_kmer_length  (r_kmer_length),
        .i_kmer_key     (i_kmer_key),
        .i_string_id    (i_string_id),
        .i_last_row     (i_last_row),
        .i_row_index    (i_row_index),
        .i_col_index    (i_col_index),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_kernel_value (o_kernel_value),
        .o_saturated    (o_saturated)
    );

endmodule

@@ rtl/skacc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectrum kernel accumulator checker
// Port-level assertions on the request and result channels.
// ----------------------------------------------------------------------------
module skacc_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             o_in_stall,
    input  logic [skacc_pkg::REQ_W-1:0]      i_req_type,
    input  logic                             o_out_valid,
    input  logic                             i_out_stall,
    input  logic [skacc_pkg::KER_W-1:0]      o_kernel_value,
    input  logic                             o_saturated
);
    import skacc_pkg::*;

    logic known_req;

    assign known_req = (i_req_type == REQ_APPEND) || (i_req_type == REQ_READ)
                    || (i_req_type == REQ_CLEAR);

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // No result is offered right after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Every accepted known request makes the block busy in the next cycle;
    // an unknown request is dropped on the spot.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && known_req |=> o_in_stall)
        else $error("request accepted back to back");

    // An entry at its maximum always reports saturation.
    a_sat_at_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kernel_value == KER_MAX) |-> o_saturated)
        else $error("saturated entry without flag");

endmodule

bind spectrum_kernel_accumulator_top skacc_checker u_skacc_checker (.*);

@@ tb/spectrum_kernel_accumulator_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectrum kernel accumulator testbench
// Sends append, read, clear and unknown requests under random idling on both
// channels. Every read result is checked against a cycle-free prediction of
// the grouping, counting and kernel accumulation. Runs at several k-mer
// lengths, including zero and lengths above the symbol count.
// ----------------------------------------------------------------------------
module spectrum_kernel_accumulator_top_tb;

    import skacc_pkg::*;

    // Request code that the block must ignore.
    localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
    // Byte address of the kmer_length register on the configuration port.
    localparam logic [APB_AW-1:0] KLEN_ADDR = APB_AW'(4 * REG_KMER_LENGTH);

    // The pause before a register write and the watchdog are sized well above
    // the close of a group over all 16 strings.
    localparam int SETTLE_CYCLES  = 900;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 400;
    localparam int PRINT_CAP      = 50;

    typedef struct {
        logic [REQ_W-1:0]      req;
        logic [KEY_W-1:0]      key;
        logic [FIELD_ID_W-1:0] sid;
        logic                  last;
        logic [FIELD_ID_W-1:0] ri;
        logic [FIELD_ID_W-1:0] ci;
    } t_kmer_request;

    typedef struct {
        logic [KER_W-1:0] value;
        logic             sat;
    } t_kernel_read;

    // ------------------------------------------------------------------------
    // Block inputs, all known from time zero.
    // ------------------------------------------------------------------------
    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  psel           = 1'b0;
    logic                  penable        = 1'b0;
    logic                  pwrite         = 1'b0;
    logic [APB_AW-1:0]     paddr          = '0;
    logic [APB_DW-1:0]     pwdata         = '0;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_stall;
    logic [REQ_W-1:0]      i_req_type     = '0;
    logic [KEY_W-1:0]      i_kmer_key     = '0;
    logic [FIELD_ID_W-1:0] i_string_id    = '0;
    logic                  i_last_row     = 1'b0;
    logic [FIELD_ID_W-1:0] i_row_index    = '0;
    logic [FIELD_ID_W-1:0] i_col_index    = '0;
    logic                  o_out_valid;
    logic                  i_out_stall    = 1'b0;
    logic [KER_W-1:0]      o_kernel_value;
    logic                  o_saturated;

    spectrum_kernel_accumulator_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_kmer_key     (i_kmer_key),
        .i_string_id    (i_string_id),
        .i_last_row     (i_last_row),
        .i_row_index    (i_row_index),
        .i_col_index    (i_col_index),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kernel_value (o_kernel_value),
        .o_saturated    (o_saturated)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Prediction state. It mirrors the block's architectural state and is
    // advanced once per accepted request transfer, in acceptance order.
    // ------------------------------------------------------------------------
    logic [KLEN_W-1:0] klen_model = KLEN_RESET;
    logic [KEY_W-1:0]  group_key_model;
    logic              group_open_model;
    logic [CNT_W-1:0]  row_count [NUM_STRINGS];
    logic              row_seen  [NUM_STRINGS];
    logic [KER_W-1:0]  kernel_mirror [STORE_DEPTH];
    logic              sat_model;

    t_kmer_request request_backlog[$];
    t_kernel_read  pending_kernel_reads[$];

    int   mismatch_count = 0;
    bit   idle_on        = 1'b0;
    bit   hold_request   = 1'b0;

    initial begin
        group_key_model  = '0;
        group_open_model = 1'b0;
        sat_model        = 1'b0;
        for (int s = 0; s < NUM_STRINGS; s++) begin
            row_count[s] = '0;
            row_seen[s]  = 1'b0;
        end
        for (int e = 0; e < STORE_DEPTH; e++) begin
            kernel_mirror[e] = '0;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < PRINT_CAP) begin
            $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        end
        mismatch_count++;
    endtask

    // Bits of the key that take part in grouping. Lengths above the symbol
    // count compare the whole key; a length of zero compares nothing.
    function automatic logic [KEY_W-1:0] grouping_mask();
        int unsigned len;
        int unsigned bits;
        len  = (klen_model > MAX_KMER) ? MAX_KMER : klen_model;
        bits = len * SYMBOL_BITS;
        if (bits >= KEY_W) begin
            return '1;
        end
        return (64'd1 << bits) - 64'd1;
    endfunction

    // Closing a group adds cnt[a]*cnt[b] to every pair of counted strings,
    // holding each entry at its maximum.
    task automatic fold_group_into_kernel();
        logic [63:0] prod;
        logic [63:0] sum;
        for (int a = 0; a < NUM_STRINGS; a++) begin
            for (int b = 0; b < NUM_STRINGS; b++) begin
                if (row_seen[a] && row_seen[b]) begin
                    prod = 64'(row_count[a]) * 64'(row_count[b]);
                    sum  = 64'(kernel_mirror[a * NUM_STRINGS + b]) + prod;
                    if (sum > 64'(KER_MAX)) begin
                        sum       = 64'(KER_MAX);
                        sat_model = 1'b1;
                    end
                    kernel_mirror[a * NUM_STRINGS + b] = sum[KER_W-1:0];
                end
            end
        end
        for (int s = 0; s < NUM_STRINGS; s++) begin
            row_count[s] = '0;
            row_seen[s]  = 1'b0;
        end
        group_open_model = 1'b0;
    endtask

    task automatic predict_spectrum_request(input t_kmer_request rq);
        t_kernel_read rd;
        case (rq.req)
            REQ_APPEND: begin
                if (group_open_model && ((group_key_model ^ rq.key) & grouping_mask()) != '0) begin
                    fold_group_into_kernel();
                end
                if (!group_open_model) begin
                    group_key_model  = rq.key;
                    group_open_model = 1'b1;
                    for (int s = 0; s < NUM_STRINGS; s++) begin
                        row_count[s] = '0;
                        row_seen[s]  = 1'b0;
                    end
                end
                if (row_count[rq.sid] >= CNT_MAX) begin
                    sat_model = 1'b1;
                end else begin
                    row_count[rq.sid] = row_count[rq.sid] + 1'b1;
                end
                row_seen[rq.sid] = 1'b1;
                if (rq.last) begin
                    fold_group_into_kernel();
                end
            end
            REQ_READ: begin
                rd.value = kernel_mirror[{rq.ri, rq.ci}];
                rd.sat   = sat_model || (rd.value == KER_MAX);
                pending_kernel_reads.push_back(rd);
            end
            REQ_CLEAR: begin
                // The open group and its counts survive a clear.
                for (int e = 0; e < STORE_DEPTH; e++) begin
                    kernel_mirror[e] = '0;
                end
                sat_model = 1'b0;
            end
            default: begin
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Request driver. A payload is held while the block stalls it; a new one
    // is offered only after the previous transfer or from idle. Random gaps
    // are sometimes inserted between requests when idling is enabled.
    // ------------------------------------------------------------------------
    t_kmer_request offered_req;
    int            send_gap = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                predict_spectrum_request(offered_req);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (request_backlog.size() > 0) begin
                    offered_req = request_backlog.pop_front();
                    i_req_type  <= offered_req.req;
                    i_kmer_key  <= offered_req.key;
                    i_string_id <= offered_req.sid;
                    i_last_row  <= offered_req.last;
                    i_row_index <= offered_req.ri;
                    i_col_index <= offered_req.ci;
                    i_in_valid  <= 1'b1;
                    if (idle_on && $urandom_range(0, 7) == 0) begin
                        send_gap = $urandom_range(1, 19);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result stall generator. Random bursts while idling is enabled, and one
    // long hold-off on request, which lets reads pile up behind the held
    // result until the block stalls its request channel.
    // ------------------------------------------------------------------------
    int stall_left = 0;
    int hold_left  = 0;
    bit hold_done  = 1'b0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (hold_request && !hold_done) begin
                hold_done   = 1'b1;
                hold_left   = LONG_HOLD - 1;
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                stall_left  = $urandom_range(0, 18);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: each result transfer is matched against the oldest
    // predicted read.
    // ------------------------------------------------------------------------
    t_kernel_read seen_want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_kernel_reads.size() == 0) begin
                report_mismatch("result with no read outstanding", 64'(o_kernel_value), '0);
            end else begin
                seen_want = pending_kernel_reads.pop_front();
                if (o_kernel_value !== seen_want.value) begin
                    report_mismatch("kernel_value", 64'(o_kernel_value), 64'(seen_want.value));
                end
                if (o_saturated !== seen_want.sat) begin
                    report_mismatch("saturated", 64'(o_saturated), 64'(seen_want.sat));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: counts cycles with no transfer on either channel and no
    // configuration access.
    // ------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no transfer for %0d cycles", $realtime, WATCHDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------

    // All fields random, so fields a request does not use still toggle.
    function automatic t_kmer_request random_request(input logic [REQ_W-1:0] req);
        t_kmer_request rq;
        rq.req  = req;
        rq.key  = {$urandom, $urandom};
        rq.sid  = FIELD_ID_W'($urandom_range(0, NUM_STRINGS - 1));
        rq.last = 1'($urandom_range(0, 1));
        rq.ri   = FIELD_ID_W'($urandom_range(0, NUM_STRINGS - 1));
        rq.ci   = FIELD_ID_W'($urandom_range(0, NUM_STRINGS - 1));
        return rq;
    endfunction

    task automatic queue_append(input logic [KEY_W-1:0] key, input int sid, input logic last);
        t_kmer_request rq;
        rq      = random_request(REQ_APPEND);
        rq.key  = key;
        rq.sid  = FIELD_ID_W'(sid);
        rq.last = last;
        request_backlog.push_back(rq);
    endtask

    task automatic queue_read(input int ri, input int ci);
        t_kmer_request rq;
        rq    = random_request(REQ_READ);
        rq.ri = FIELD_ID_W'(ri);
        rq.ci = FIELD_ID_W'(ci);
        request_backlog.push_back(rq);
    endtask

    // Wait until every request has been taken and every read answered, then
    // give the block time to finish a group close that produces no result.
    task automatic drain_block();
        while (request_backlog.size() > 0 || i_in_valid || pending_kernel_reads.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write kmer_length, then read it back in the following access.
    task automatic program_kmer_length(input logic [KLEN_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= KLEN_ADDR;
        pwdata  <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        klen_model = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== APB_DW'(value)) begin
            report_mismatch("kmer_length read back", 64'(prdata), 64'(value));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Sorted-list style traffic: most rows repeat or slightly alter the
    // previous key so groups form and close, with a few reads, clears and
    // unknown requests mixed in. String ids mostly come from a small pool so
    // that closing a group stays short.
    task automatic queue_random_traffic(input int n_items);
        logic [KEY_W-1:0]      key;
        logic [FIELD_ID_W-1:0] pool [4];
        int                    pick;
        int                    sym;
        t_kmer_request         rq;
        key = {$urandom, $urandom};
        for (int p = 0; p < 4; p++) begin
            pool[p] = FIELD_ID_W'($urandom_range(0, NUM_STRINGS - 1));
        end
        for (int n = 0; n < n_items; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 18) begin
                rq = random_request(REQ_READ);
                if ($urandom_range(0, 1) == 1) begin
                    rq.ri = pool[$urandom_range(0, 3)];
                    rq.ci = pool[$urandom_range(0, 3)];
                end
                request_backlog.push_back(rq);
            end else if (pick < 19) begin
                request_backlog.push_back(random_request(REQ_CLEAR));
            end else if (pick < 20) begin
                request_backlog.push_back(random_request(REQ_UNKNOWN));
            end else begin
                pick = $urandom_range(0, 99);
                if (pick >= 75) begin
                    key = {$urandom, $urandom};
                end else if (pick >= 40) begin
                    // Changing one symbol splits the group only when that
                    // symbol is inside the compared length.
                    sym = $urandom_range(0, MAX_KMER - 1);
                    key[sym * SYMBOL_BITS +: SYMBOL_BITS] = SYMBOL_BITS'($urandom);
                end
                rq      = random_request(REQ_APPEND);
                rq.key  = key;
                rq.last = ($urandom_range(0, 7) == 0);
                if ($urandom_range(0, 4) != 0) begin
                    rq.sid = pool[$urandom_range(0, 3)];
                end
                request_backlog.push_back(rq);
            end
        end
        // A closing read guarantees the block is idle once it is answered.
        queue_read($urandom_range(0, NUM_STRINGS - 1), $urandom_range(0, NUM_STRINGS - 1));
    endtask

    task automatic run_traffic_phase(input logic [KLEN_W-1:0] klen, input int n_items,
                                     input bit idling, input bit hold);
        program_kmer_length(klen);
        idle_on      = idling;
        hold_request = hold;
        queue_random_traffic(n_items);
        drain_block();
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset length, with idling on both sides.
        idle_on = 1'b1;
        // A read right after reset sees an empty store.
        queue_read(0, 0);
        // One group spread over every string id, all-ones key, closed by the
        // last-row flag: the widest close the block can do.
        for (int s = 0; s < NUM_STRINGS; s++) begin
            queue_append('1, s, s == NUM_STRINGS - 1);
        end
        queue_read(NUM_STRINGS - 1, 0);
        queue_read(0, NUM_STRINGS - 1);
        // A clear keeps the open group: the row before it still counts.
        queue_append('0, 5, 1'b0);
        request_backlog.push_back(random_request(REQ_CLEAR));
        queue_append('0, 5, 1'b1);
        queue_read(5, 5);
        // An unknown request is dropped and returns nothing.
        request_backlog.push_back(random_request(REQ_UNKNOWN));
        queue_read(NUM_STRINGS - 1, NUM_STRINGS - 1);
        drain_block();

        // Random phases over several lengths: the shortest and longest legal
        // lengths, zero, and the largest value the register holds.
        run_traffic_phase(KLEN_W'(1), 310, 1'b1, 1'b0);
        run_traffic_phase(KLEN_W'(0), 310, 1'b1, 1'b1);
        run_traffic_phase(KLEN_W'(15), 310, 1'b0, 1'b0);
        run_traffic_phase(KLEN_W'(3), 310, 1'b1, 1'b0);
        run_traffic_phase(KLEN_W'(MAX_KMER), 310, 1'b1, 1'b0);
        // The last part runs without idling on either side.
        run_traffic_phase(KLEN_W'($urandom_range(0, 15)), 300, 1'b0, 1'b0);

        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
